>>> src/cartesian_to_polar_radar_core_assert.svh
// assertion macros used by the port-level checker of the radar core
// no dependencies
`ifndef CARTESIAN_TO_POLAR_RADAR_CORE_ASSERT_SVH
`define CARTESIAN_TO_POLAR_RADAR_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define C2P_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2p assertion failed");

// condition holds in the cycle after the trigger
`define C2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2p assertion failed");

`endif

>>> src/c2p_pkg.sv
// shared types, constants and the arctangent table of the radar core
// no dependencies
package c2p_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_B     = 16;
    localparam int ANG_FRAC   = 30;
    localparam int XY_GUARD   = 20;
    localparam int XW         = 56;   // cordic x/y width
    localparam int ZW         = 35;   // cordic angle width, Q30
    localparam int PHI_W      = 19;
    localparam int EPS_W      = 16;
    localparam int C2P_CORDIC_STAGES = 24;

    localparam logic [31:0]          INV_GAIN = 32'd2608131496;
    localparam logic signed [ZW-1:0] PI_ANG   = 35'sd3373259426;
    localparam logic signed [20:0]   PI_OUT   = 21'sd205887;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               zero;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] rho;
        logic [PHI_W-1:0]  phi;
        logic              neg;
        logic              big;
        logic              rz;
    } t_dside;

    // atan(2^-i) in Q30, rounded
    function automatic logic [ZW-1:0] atan_q30(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = 35'd843314857;
            1:       v = 35'd497837829;
            2:       v = 35'd263043837;
            3:       v = 35'd133525159;
            4:       v = 35'd67021687;
            5:       v = 35'd33543516;
            6:       v = 35'd16775851;
            7:       v = 35'd8388437;
            8:       v = 35'd4194283;
            9:       v = 35'd2097149;
            10:      v = 35'd1048576;
            // half an lsb rounds up at the last stage
            31:      v = 35'd1;
            default: v = (idx <= 30) ? (35'd1 << (30 - idx)) : 35'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/c2p_cordic_cell.sv
// one vectoring cordic micro-rotation with a registered output
// depends on c2p_pkg
module c2p_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [c2p_pkg::XW-1:0] i_x,
    input  logic signed [c2p_pkg::XW-1:0] i_y,
    input  logic signed [c2p_pkg::ZW-1:0] i_z,
    input  c2p_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic signed [c2p_pkg::XW-1:0] o_x,
    output logic signed [c2p_pkg::XW-1:0] o_y,
    output logic signed [c2p_pkg::ZW-1:0] o_z,
    output c2p_pkg::t_side                o_side
);
    import c2p_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

    logic signed [XW-1:0] xs, ys, n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

>>> src/c2p_div_cell.sv
// one restoring division step, one quotient bit, registered output
// depends on c2p_pkg
module c2p_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [c2p_pkg::DATA_W-1:0] i_rem,
    input  logic [c2p_pkg::DATA_W-1:0] i_low,
    input  logic [c2p_pkg::DATA_W-1:0] i_q,
    input  c2p_pkg::t_dside           i_side,
    output logic                      o_valid,
    output logic [c2p_pkg::DATA_W-1:0] o_rem,
    output logic [c2p_pkg::DATA_W-1:0] o_low,
    output logic [c2p_pkg::DATA_W-1:0] o_q,
    output c2p_pkg::t_dside           o_side
);
    import c2p_pkg::*;

    logic [DATA_W:0]   t;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] n_rem;
    logic              r_valid;
    logic [DATA_W-1:0] r_rem, r_low, r_q;
    t_dside            r_side;

    always_comb begin
        t    = {i_rem, i_low[DATA_W-1]};
        diff = t - {1'b0, i_side.rho};
        qbit = (t >= {1'b0, i_side.rho});
        n_rem = qbit ? diff[DATA_W-1:0] : t[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_low  <= {i_low[DATA_W-2:0], 1'b0};
            r_q    <= {i_q[DATA_W-2:0], qbit};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule

>>> src/cartesian_to_polar_radar_core.sv
// input to result: stages 0, 1, cordic cells, g1 to g3, divider cells, final stage
// throughput: one transaction per cycle, set by the cordic and divider cell chains,
// but the whole pipeline stalls as one while a result waits at the output
// reset: synchronous active low, clears all valid flags and sets eps_lsb to 1
// no clearing pass; the block is ready in the cycle after reset is released
// depends on c2p_pkg, c2p_cordic_cell and c2p_div_cell
module cartesian_to_polar_radar_core #(
    parameter int CORDIC_STAGES = c2p_pkg::C2P_CORDIC_STAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // px [31:0], py [63:32], vx [95:64], vy [127:96]
    input  logic [127:0]  i_s_axis_tdata,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // range_out [31:0], bearing_out [50:32], range_rate [82:51],
    // rate_saturated [83], zero [87:84]
    output logic [87:0]   o_m_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // eps_lsb write channel
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_data,
    output logic          o_cfg_ready
);
    import c2p_pkg::*;

    // global advance: everything moves unless the result is stuck
    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    logic [EPS_W-1:0] r_eps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // ---------------- stage 0: px clamp ----------------
    logic signed [31:0] in_px, in_py;
    logic signed [32:0] pxs, upx;
    logic signed [31:0] n0_px;
    assign in_px = i_s_axis_tdata[31:0];
    assign in_py = i_s_axis_tdata[63:32];

    always_comb begin
        pxs   = {in_px[31], in_px};
        upx   = pxs[32] ? -pxs : pxs;
        n0_px = (upx < $signed({17'd0, r_eps})) ? $signed({16'd0, r_eps}) : in_px;
    end

    logic               r0_v, r0_zero;
    logic signed [31:0] r0_px, r0_py, r0_vx, r0_vy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_px   <= n0_px;
            r0_py   <= in_py;
            r0_vx   <= i_s_axis_tdata[95:64];
            r0_vy   <= i_s_axis_tdata[127:96];
            r0_zero <= (n0_px == 32'sd0) && (in_py == 32'sd0);
        end
    end

    // ---------------- stage 1: pre-rotation and dot products ----------------
    logic signed [XW-1:0] xg, yg, n1_x, n1_y;
    logic signed [ZW-1:0] n1_z;
    always_comb begin
        xg = XW'(r0_px) <<< XY_GUARD;
        yg = XW'(r0_py) <<< XY_GUARD;
        if (r0_px[31]) begin
            // left half plane: rotate by pi first
            n1_x = -xg;
            n1_y = -yg;
            n1_z = r0_py[31] ? -PI_ANG : PI_ANG;
        end else begin
            n1_x = xg;
            n1_y = yg;
            n1_z = '0;
        end
    end

    logic                 r1_v;
    logic signed [XW-1:0] r1_x, r1_y;
    logic signed [ZW-1:0] r1_z;
    t_side                r1_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x         <= n1_x;
            r1_y         <= n1_y;
            r1_z         <= n1_z;
            r1_side.a    <= 64'(r0_px) * 64'(r0_vx);
            r1_side.b    <= 64'(r0_py) * 64'(r0_vy);
            r1_side.zero <= r0_zero;
        end
    end

    // ---------------- cordic cell chain ----------------
    logic                 c_v    [0:CORDIC_STAGES];
    logic signed [XW-1:0] c_x    [0:CORDIC_STAGES];
    logic signed [XW-1:0] c_y    [0:CORDIC_STAGES];
    logic signed [ZW-1:0] c_z    [0:CORDIC_STAGES];
    t_side                c_side [0:CORDIC_STAGES];

    assign c_v[0]    = r1_v;
    assign c_x[0]    = r1_x;
    assign c_y[0]    = r1_y;
    assign c_z[0]    = r1_z;
    assign c_side[0] = r1_side;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        c2p_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_v[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_v[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // ---------------- stage g1: gain products, bearing, dot sign ----------------
    logic [XW-1:0]        ux;
    logic signed [64:0]   dot;
    logic signed [ZW-1:0] zr_full;
    logic signed [20:0]   zr, phi_c;
    always_comb begin
        ux      = c_x[CORDIC_STAGES][XW-1] ? '0 : c_x[CORDIC_STAGES];
        dot     = 65'(c_side[CORDIC_STAGES].a) + 65'(c_side[CORDIC_STAGES].b);
        // round half up to Q16
        zr_full = (c_z[CORDIC_STAGES] + ZW'(1 << (ANG_FRAC - FRAC_B - 1)))
                  >>> (ANG_FRAC - FRAC_B);
        zr      = zr_full[20:0];
        if (zr > PI_OUT) begin
            phi_c = PI_OUT;
        end else if (zr < -PI_OUT) begin
            phi_c = -PI_OUT;
        end else begin
            phi_c = zr;
        end
    end

    logic                r2_v, r2_zero, r2_neg;
    logic [XW-1:0]       r2_hc;
    logic [63:0]         r2_lc;
    logic [63:0]         r2_mag;
    logic [PHI_W-1:0]    r2_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= c_v[CORDIC_STAGES];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_hc   <= XW'(ux[XW-1:32]) * XW'(INV_GAIN);
            r2_lc   <= 64'(ux[31:0]) * 64'(INV_GAIN);
            r2_neg  <= dot[64];
            r2_mag  <= dot[64] ? 64'(-dot) : dot[63:0];
            r2_zero <= c_side[CORDIC_STAGES].zero;
            r2_phi  <= c_side[CORDIC_STAGES].zero ? '0 : phi_c[PHI_W-1:0];
        end
    end

    // ---------------- stage g2: range rounding and clamps ----------------
    logic [XW:0]       p;
    logic [XW:0]       pr;
    logic [DATA_W-1:0] rho_s, rho_c;
    always_comb begin
        p  = {1'b0, r2_hc} + (XW+1)'(r2_lc[63:32]);
        pr = (p + (XW+1)'(1 << (XY_GUARD - 1))) >> XY_GUARD;
        rho_s = (pr > (XW+1)'({DATA_W{1'b1}})) ? {DATA_W{1'b1}} : pr[DATA_W-1:0];
        if (r2_zero) begin
            rho_s = '0;
        end
        rho_c = (rho_s < DATA_W'(r_eps)) ? DATA_W'(r_eps) : rho_s;
    end

    logic              r3_v, r3_neg;
    logic [DATA_W-1:0] r3_rho;
    logic [63:0]       r3_mag;
    logic [PHI_W-1:0]  r3_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rho <= rho_c;
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_phi <= r2_phi;
        end
    end

    // ---------------- stage g3: rounded dividend and overflow check ----------------
    logic [63:0] num;
    assign num = r3_mag + 64'(r3_rho >> 1);

    logic              r4_v;
    logic [DATA_W-1:0] r4_rem, r4_low;
    t_dside            r4_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_rem       <= num[63:32];
            r4_low       <= num[31:0];
            r4_side.rho  <= r3_rho;
            r4_side.phi  <= r3_phi;
            r4_side.neg  <= r3_neg;
            // quotient would need more than 32 bits
            r4_side.big  <= (num[63:32] >= r3_rho);
            r4_side.rz   <= (r3_rho == '0);
        end
    end

    // ---------------- divider cell chain ----------------
    logic              d_v    [0:DATA_W];
    logic [DATA_W-1:0] d_rem  [0:DATA_W];
    logic [DATA_W-1:0] d_low  [0:DATA_W];
    logic [DATA_W-1:0] d_q    [0:DATA_W];
    t_dside            d_side [0:DATA_W];

    assign d_v[0]    = r4_v;
    assign d_rem[0]  = r4_rem;
    assign d_low[0]  = r4_low;
    assign d_q[0]    = '0;
    assign d_side[0] = r4_side;

    for (genvar k = 0; k < DATA_W; k++) begin : g_div
        c2p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_v[k]),
            .i_rem   (d_rem[k]),
            .i_low   (d_low[k]),
            .i_q     (d_q[k]),
            .i_side  (d_side[k]),
            .o_valid (d_v[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_low   (d_low[k+1]),
            .o_q     (d_q[k+1]),
            .o_side  (d_side[k+1])
        );
    end

    // ---------------- final stage: saturation and output register ----------------
    localparam logic [DATA_W-1:0] LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    t_dside            fs;
    logic [DATA_W-1:0] q, n_rate;
    logic              n_sat;
    always_comb begin
        fs = d_side[DATA_W];
        q  = d_q[DATA_W];
        n_rate = '0;
        n_sat  = 1'b0;
        if (fs.rz) begin
            n_rate = '0;
        end else if (!fs.neg) begin
            if (fs.big || q > LIM_POS) begin
                n_rate = LIM_POS;
                n_sat  = 1'b1;
            end else begin
                n_rate = q;
            end
        end else begin
            if (fs.big || q > LIM_NEG) begin
                n_rate = LIM_NEG;
                n_sat  = 1'b1;
            end else begin
                n_rate = -q;
            end
        end
    end

    logic              r_ov, r_sat;
    logic [DATA_W-1:0] r_rho, r_rate;
    logic [PHI_W-1:0]  r_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_v[DATA_W];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho  <= fs.rho;
            r_phi  <= fs.phi;
            r_rate <= n_rate;
            r_sat  <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'd0, r_sat, r_rate, r_phi, r_rho};

endmodule

>>> src/c2p_checker.sv
// port-level checks of the radar core result stream, bound to the top level
// depends on cartesian_to_polar_radar_core_assert.svh
`include "cartesian_to_polar_radar_core_assert.svh"

module c2p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata
);

    logic [31:0]        rho;
    logic signed [18:0] bearing;
    logic [31:0]        rate;
    logic               sat;
    logic               stall;

    assign rho     = o_m_axis_tdata[31:0];
    assign bearing = o_m_axis_tdata[50:32];
    assign rate    = o_m_axis_tdata[82:51];
    assign sat     = o_m_axis_tdata[83];
    assign stall   = o_m_axis_tvalid && !i_m_axis_tready;

    // stalled result holds
    `C2P_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // bearing stays within minus pi to pi
    `C2P_ASSERT_SAME(a_bearing, i_clk, i_rst_n, o_m_axis_tvalid, (bearing <= 19'sd205887) && (bearing >= -19'sd205887))

    // saturation flag only with a limit value
    `C2P_ASSERT_SAME(a_sat, i_clk, i_rst_n, o_m_axis_tvalid && sat, (rate == 32'h7fffffff) || (rate == 32'h80000000))

    // zero range gives zero rate and no flag
    `C2P_ASSERT_SAME(a_zero, i_clk, i_rst_n, o_m_axis_tvalid && (rho == 32'd0), (rate == 32'd0) && !sat)

endmodule

bind cartesian_to_polar_radar_core c2p_checker u_c2p_checker (.*);
